// ===== rtl/cdchk_pkg.sv =====
package cdchk_pkg;

	localparam int DEPTH       = 64;
	localparam int VALUE_WIDTH = 32;
	localparam int CNT_W       = $clog2(DEPTH + 1);

	typedef logic signed [VALUE_WIDTH-1:0] value_t;

	// request opcodes
	typedef enum logic [1:0] {
		MODE_PUSH = 2'd0,
		MODE_POP  = 2'd1,
		MODE_END  = 2'd2
	} mode_e;

	typedef enum logic [2:0] {
		VERDICT_NONE   = 3'd0,
		VERDICT_STACK  = 3'd1,
		VERDICT_QUEUE  = 3'd2,
		VERDICT_MIN_PQ = 3'd3,
		VERDICT_MAX_PQ = 3'd4,
		VERDICT_UNSURE = 3'd5
	} verdict_e;

	// positions in the mask of disciplines
	localparam int BIT_STACK  = 0;
	localparam int BIT_QUEUE  = 1;
	localparam int BIT_MIN_PQ = 2;
	localparam int BIT_MAX_PQ = 3;

	typedef struct packed {
		logic [1:0] mode;
		value_t     value;
	} cmd_t;

	typedef struct packed {
		verdict_e   verdict;
		logic [3:0] possible_mask;
		logic       overflow;
	} res_t;

	// broadcast to every cell
	typedef struct packed {
		logic             push;
		logic             pop;
		value_t           value;
		logic [CNT_W-1:0] count;
	} cell_ctl_t;

	// what a cell shows to its neighbors
	typedef struct packed {
		value_t stk;
		value_t que;
		value_t mn;
		value_t mx;
		logic   mn_before;
		logic   mx_before;
	} cell_link_t;

	localparam cell_link_t LINK_NONE = '0;

	function automatic verdict_e verdict_of(input logic [3:0] mask);
		verdict_e v;
		v = VERDICT_NONE;
		if ($countones(mask) > 1)
			v = VERDICT_UNSURE;
		else if (mask[BIT_STACK])
			v = VERDICT_STACK;
		else if (mask[BIT_QUEUE])
			v = VERDICT_QUEUE;
		else if (mask[BIT_MIN_PQ])
			v = VERDICT_MIN_PQ;
		else if (mask[BIT_MAX_PQ])
			v = VERDICT_MAX_PQ;
		return v;
	endfunction

endpackage

// ===== rtl/cdchk_cell.sv =====
module cdchk_cell
	import cdchk_pkg::*;
(
	input  logic             clk,
	input  cell_ctl_t        ctl,
	input  logic [CNT_W-1:0] idx,
	input  cell_link_t       from_prev,
	input  cell_link_t       from_next,
	output cell_link_t       link
);

	value_t stk_q;
	value_t que_q;
	value_t mn_q;
	value_t mx_q;

	logic below;
	logic at;
	logic mn_before;
	logic mx_before;

	// locate this cell against the fill level and the new value
	assign below     = idx < ctl.count;
	assign at        = idx == ctl.count;
	assign mn_before = below & (ctl.value < mn_q);
	assign mx_before = below & (mx_q < ctl.value);

	assign link.stk       = stk_q;
	assign link.que       = que_q;
	assign link.mn        = mn_q;
	assign link.mx        = mx_q;
	assign link.mn_before = mn_before;
	assign link.mx_before = mx_before;

	// push: shift stack down, append queue, insert into sorted chains
	// pop: advance every chain one cell toward the head
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			stk_q <= (idx == '0) ? ctl.value : from_prev.stk;
			if (at)
				que_q <= ctl.value;
			if (mn_before || at)
				mn_q <= from_prev.mn_before ? from_prev.mn : ctl.value;
			if (mx_before || at)
				mx_q <= from_prev.mx_before ? from_prev.mx : ctl.value;
		end else if (ctl.pop) begin
			stk_q <= from_next.stk;
			que_q <= from_next.que;
			mn_q  <= from_next.mn;
			mx_q  <= from_next.mx;
		end
	end

endmodule

// ===== rtl/container_discipline_checker.sv =====
// Container discipline checker.
// Requests arrive on cmd (cmd_valid / cmd_stall): push a value, pop with the
// observed value, or end of sequence. Each push enters a stack, a queue, a
// min-priority and a max-priority chain of DEPTH cells; each pop compares the
// value with the four heads and rules out the disciplines that differ.
// Only an end-of-sequence request gives a result on res (res_valid /
// res_stall): the verdict, the mask of disciplines still possible and the
// overflow flag; the sequence state is then cleared for the next trace.
// Every request is handled in a single step: the cell chain shifts or inserts
// at once, so one request is accepted each cycle while cmd_stall is low. A
// result is registered and appears on res in the cycle after its end request
// is accepted, and is held in one output register.
// cmd_stall rises only while a result waits in that register and res_stall
// is high; it holds the register contents stable until taken.
// Pushes beyond DEPTH are dropped and set the overflow flag; a pop on an
// empty container rules out every discipline.
// Reset (arst_n low) empties the containers, marks all four disciplines
// possible, clears overflow and drops any pending result.
module container_discipline_checker
	import cdchk_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_stall,
	input  cmd_t cmd,
	output logic res_valid,
	input  logic res_stall,
	output res_t res
);

	logic [CNT_W-1:0] count_q;
	logic [3:0]       mask_q;
	logic             overflow_q;
	logic             res_valid_q;
	res_t             res_q;

	logic accept;
	logic full;
	logic empty;
	logic do_push;
	logic drop_push;
	logic do_pop;
	logic pop_empty;
	logic do_end;
	logic [3:0] miss;

	cell_ctl_t  ctl;
	cell_link_t links [DEPTH];

	// hold requests while an untaken result blocks the output register
	assign cmd_stall = res_valid_q & res_stall;
	assign accept    = cmd_valid & ~cmd_stall;

	assign full      = count_q == CNT_W'(DEPTH);
	assign empty     = count_q == '0;
	assign do_push   = accept & (cmd.mode == MODE_PUSH) & ~full;
	assign drop_push = accept & (cmd.mode == MODE_PUSH) & full;
	assign do_pop    = accept & (cmd.mode == MODE_POP) & ~empty;
	assign pop_empty = accept & (cmd.mode == MODE_POP) & empty;
	assign do_end    = accept & (cmd.mode == MODE_END);

	assign ctl.push  = do_push;
	assign ctl.pop   = do_pop;
	assign ctl.value = cmd.value;
	assign ctl.count = count_q;

	// build the row of cells, head at cell zero
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		cell_link_t prev_link;
		cell_link_t next_link;
		if (i == 0) begin : g_first
			assign prev_link = LINK_NONE;
		end else begin : g_inner
			assign prev_link = links[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign next_link = LINK_NONE;
		end else begin : g_more
			assign next_link = links[i+1];
		end
		cdchk_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.idx       (CNT_W'(i)),
			.from_prev (prev_link),
			.from_next (next_link),
			.link      (links[i])
		);
	end

	// compare the popped value with each head
	assign miss[BIT_STACK]  = links[0].stk != cmd.value;
	assign miss[BIT_QUEUE]  = links[0].que != cmd.value;
	assign miss[BIT_MIN_PQ] = links[0].mn  != cmd.value;
	assign miss[BIT_MAX_PQ] = links[0].mx  != cmd.value;

	// track fill level, surviving disciplines and overflow
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			mask_q     <= '1;
			overflow_q <= 1'b0;
		end else if (do_end) begin
			count_q    <= '0;
			mask_q     <= '1;
			overflow_q <= 1'b0;
		end else begin
			if (do_push)
				count_q <= count_q + CNT_W'(1);
			else if (do_pop)
				count_q <= count_q - CNT_W'(1);
			if (drop_push)
				overflow_q <= 1'b1;
			if (pop_empty)
				mask_q <= '0;
			else if (do_pop)
				mask_q <= mask_q & ~miss;
		end
	end

	// load the verdict on end of sequence, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (do_end)
			res_valid_q <= 1'b1;
		else if (!res_stall)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (do_end) begin
			res_q.verdict       <= verdict_of(mask_q);
			res_q.possible_mask <= mask_q;
			res_q.overflow      <= overflow_q | drop_push;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("element count beyond capacity");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		do_end |=> (count_q == '0) && (mask_q == 4'hF) && !overflow_q)
		else $error("sequence state not cleared after end");

	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop_empty |=> mask_q == 4'h0)
		else $error("pop on empty left a discipline possible");

	a_res_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(do_end))
		else $error("result without end of sequence");

	a_mask_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		$past(!do_end) && $past(arst_n) |-> (mask_q & ~$past(mask_q)) == 4'h0)
		else $error("discipline revived within a sequence");

endmodule

// ===== tb/discipline_check.sv =====
`timescale 1ns / 1ps

// Watches both channels, keeps its own copy of the four candidate containers,
// and compares every verdict that leaves the block with the one it expects.
module discipline_check
	import cdchk_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	input  logic cmd_stall,
	input  cmd_t cmd,
	input  logic res_valid,
	input  logic res_stall,
	input  res_t res,
	output int   mismatches,
	output int   outstanding
);

	// candidate containers for the trace in progress
	value_t     stack_cells [DEPTH];
	value_t     fifo_cells  [DEPTH];
	value_t     asc_cells   [DEPTH];
	value_t     desc_cells  [DEPTH];
	int         fifo_head;
	int         held_count;
	logic [3:0] alive;
	logic       dropped_push;

	res_t       verdicts_due[$];
	int         fail_total = 0;

	value_t     v;
	int         i;
	int         tail;
	res_t       due;
	res_t       want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fifo_head    = 0;
			held_count   = 0;
			alive        = 4'hf;
			dropped_push = 1'b0;
			fail_total   = 0;
			verdicts_due.delete();
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			// compare a taken verdict with the oldest one due
			if (res_valid && !res_stall) begin
				if (verdicts_due.size() == 0) begin
					$error("unexpected result: verdict %0d, possible_mask %0h, overflow %0b",
						res.verdict, res.possible_mask, res.overflow);
					fail_total++;
				end else begin
					want = verdicts_due.pop_front();
					if (res.verdict !== want.verdict) begin
						$error("verdict: expected %0d, got %0d", want.verdict, res.verdict);
						fail_total++;
					end
					if (res.possible_mask !== want.possible_mask) begin
						$error("possible_mask: expected %0h, got %0h",
							want.possible_mask, res.possible_mask);
						fail_total++;
					end
					if (res.overflow !== want.overflow) begin
						$error("overflow: expected %0b, got %0b", want.overflow, res.overflow);
						fail_total++;
					end
				end
			end

			// advance the candidates by one accepted request
			if (cmd_valid && !cmd_stall) begin
				v = cmd.value;
				case (cmd.mode)
					MODE_PUSH: begin
						if (held_count >= DEPTH) begin
							dropped_push = 1'b1;
						end else begin
							tail = (fifo_head + held_count) % DEPTH;
							stack_cells[held_count] = v;
							fifo_cells[tail] = v;
							// shift larger entries up, keep smallest at index 0
							i = held_count;
							while (i > 0) begin
								if (!(v < asc_cells[i-1]))
									break;
								asc_cells[i] = asc_cells[i-1];
								i--;
							end
							asc_cells[i] = v;
							// shift smaller entries up, keep largest at index 0
							i = held_count;
							while (i > 0) begin
								if (!(desc_cells[i-1] < v))
									break;
								desc_cells[i] = desc_cells[i-1];
								i--;
							end
							desc_cells[i] = v;
							held_count++;
						end
					end
					MODE_POP: begin
						if (held_count == 0) begin
							alive = 4'h0;
						end else begin
							if (stack_cells[held_count-1] != v)
								alive[BIT_STACK] = 1'b0;
							if (fifo_cells[fifo_head] != v)
								alive[BIT_QUEUE] = 1'b0;
							if (asc_cells[0] != v)
								alive[BIT_MIN_PQ] = 1'b0;
							if (desc_cells[0] != v)
								alive[BIT_MAX_PQ] = 1'b0;
							for (i = 1; i < held_count; i++) begin
								asc_cells[i-1]  = asc_cells[i];
								desc_cells[i-1] = desc_cells[i];
							end
							fifo_head = (fifo_head + 1) % DEPTH;
							held_count--;
						end
					end
					MODE_END: begin
						case (alive)
							4'b0000: due.verdict = VERDICT_NONE;
							4'b0001: due.verdict = VERDICT_STACK;
							4'b0010: due.verdict = VERDICT_QUEUE;
							4'b0100: due.verdict = VERDICT_MIN_PQ;
							4'b1000: due.verdict = VERDICT_MAX_PQ;
							default: due.verdict = VERDICT_UNSURE;
						endcase
						due.possible_mask = alive;
						due.overflow      = dropped_push;
						verdicts_due.push_back(due);
						fifo_head    = 0;
						held_count   = 0;
						alive        = 4'hf;
						dropped_push = 1'b0;
					end
					default: begin
						// unused code: no effect
					end
				endcase
			end

			mismatches  <= fail_total;
			outstanding <= verdicts_due.size();
		end
	end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import cdchk_pkg::*;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int         QUIET_LIMIT = 2000;
	localparam int         PHASE_ITEMS = 257;
	localparam value_t     VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
	localparam value_t     VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

	typedef enum int {
		AS_STACK,
		AS_QUEUE,
		AS_MIN_PQ,
		AS_MAX_PQ
	} shape_e;

	logic clk = 1'b0;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	cmd_t cmd;
	logic res_valid;
	logic res_stall;
	res_t res;
	int   mismatches;
	int   outstanding;

	int     sent_count = 0;
	int     sender_idle = 0;
	int     stall_pct = 0;
	int     quiet_cycles = 0;
	value_t trace_shadow[$];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	container_discipline_checker dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	discipline_check checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_stall   (cmd_stall),
		.cmd         (cmd),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.res         (res),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// stall the result channel at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_stall <= 1'b0;
		else
			res_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// end the run when nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// hand one request to the block, with random idle cycles ahead of it
	task automatic send_request(input logic [1:0] mode, input value_t value);
		cmd_t req;
		req.mode  = mode;
		req.value = value;
		while ($urandom_range(0, 99) < sender_idle) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd       <= req;
		do
			@(posedge clk);
		while (cmd_stall);
		if (mode != MODE_UNUSED)
			sent_count++;
	endtask

	function automatic value_t pick_value();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return value_t'($urandom_range(0, 6)) - value_t'(3);
			8: return $urandom_range(0, 1) ? VAL_MIN : VAL_MAX;
			default: return value_t'($urandom);
		endcase
	endfunction

	// pop the head that the chosen discipline dictates, sometimes corrupted
	task automatic pop_shadow(input shape_e shape, input bit broken);
		int     idx;
		int     i;
		value_t v;
		idx = (shape == AS_STACK) ? trace_shadow.size() - 1 : 0;
		for (i = 1; i < trace_shadow.size(); i++) begin
			if (shape == AS_MIN_PQ && trace_shadow[i] < trace_shadow[idx])
				idx = i;
			if (shape == AS_MAX_PQ && trace_shadow[i] > trace_shadow[idx])
				idx = i;
		end
		v = trace_shadow[idx];
		trace_shadow.delete(idx);
		if (broken && $urandom_range(0, 3) == 0)
			v = v ^ (value_t'(1) << $urandom_range(0, VALUE_WIDTH - 1));
		send_request(MODE_POP, v);
	endtask

	// one trace: mostly well-formed for one discipline, else noise
	task automatic run_trace(input bit fill);
		int     flavor;
		int     steps;
		int     pops;
		int     k;
		shape_e shape;
		bit     broken;
		value_t v;
		flavor = $urandom_range(0, 9);
		trace_shadow.delete();
		if (!fill && flavor == 9) begin
			steps = $urandom_range(1, 12);
			for (k = 0; k < steps; k++)
				send_request(2'($urandom_range(0, 3)), value_t'($urandom));
		end else begin
			shape  = shape_e'($urandom_range(0, 3));
			broken = (flavor == 8);
			steps  = fill ? DEPTH + $urandom_range(1, 3) : $urandom_range(1, 20);
			for (k = 0; k < steps; k++) begin
				if (fill || trace_shadow.size() == 0 || $urandom_range(0, 1)) begin
					v = pick_value();
					send_request(MODE_PUSH, v);
					// drop what the block drops when full
					if (trace_shadow.size() < DEPTH)
						trace_shadow.push_back(v);
				end else begin
					pop_shadow(shape, broken);
				end
			end
			pops = $urandom_range(0, 1) ? trace_shadow.size()
				: $urandom_range(0, trace_shadow.size());
			for (k = 0; k < pops; k++)
				pop_shadow(shape, broken);
		end
		send_request(MODE_END, value_t'($urandom));
	endtask

	initial begin
		int p;
		int goal;
		arst_n    <= 1'b0;
		cmd_valid <= 1'b0;
		cmd       <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// verdict on an empty trace
		send_request(MODE_END, '0);
		// pop on empty rules out everything
		send_request(MODE_POP, VAL_MAX);
		send_request(MODE_END, '0);
		// only a stack fits
		send_request(MODE_PUSH, 1);
		send_request(MODE_PUSH, 3);
		send_request(MODE_PUSH, 2);
		send_request(MODE_POP, 2);
		send_request(MODE_POP, 3);
		send_request(MODE_POP, 1);
		send_request(MODE_END, '0);
		// only a queue fits
		send_request(MODE_PUSH, 3);
		send_request(MODE_PUSH, 1);
		send_request(MODE_PUSH, 2);
		send_request(MODE_POP, 3);
		send_request(MODE_POP, 1);
		send_request(MODE_POP, 2);
		send_request(MODE_END, '0);
		// extreme values: stack and max priority both fit
		send_request(MODE_PUSH, VAL_MIN);
		send_request(MODE_PUSH, VAL_MAX);
		send_request(MODE_POP, VAL_MAX);
		send_request(MODE_POP, VAL_MIN);
		send_request(MODE_END, VAL_MAX);
		// unused code is ignored
		send_request(MODE_UNUSED, VAL_MIN);
		send_request(MODE_END, '0);

		// random traces under each idling pattern
		for (p = 0; p < 4; p++) begin
			case (p)
				0: begin
					sender_idle = 0;
					stall_pct   = 0;
				end
				1: begin
					sender_idle = 82;
					stall_pct   = 0;
				end
				2: begin
					sender_idle = 0;
					stall_pct   = 82;
				end
				default: begin
					sender_idle = 19;
					stall_pct   = 19;
				end
			endcase
			goal = sent_count + PHASE_ITEMS;
			run_trace(1'b1);
			while (sent_count < goal)
				run_trace($urandom_range(0, 39) == 0);
		end
		cmd_valid <= 1'b0;

		// let the checker count the last request, drain the verdicts, then settle
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
